[sv/mesp_pkg.sv]
// Shared types and constants of the MIDI event stream parser.
package mesp_pkg;

  localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
  localparam logic [2:0] KIND_PROGRAM  = 3'd2;
  localparam logic [2:0] KIND_PRESSURE = 3'd3;
  localparam logic [2:0] KIND_BEND     = 3'd4;
  localparam logic [2:0] KIND_TEMPO    = 3'd5;
  localparam logic [2:0] KIND_END      = 3'd6;
  localparam logic [2:0] KIND_ERROR    = 3'd7;

  localparam logic [7:0] STATUS_META    = 8'hff;
  localparam logic [7:0] META_END_TRACK = 8'h2f;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
  localparam logic [3:0] HI_NOTE_ON     = 4'h9;
  localparam logic [3:0] HI_PROGRAM     = 4'hc;
  localparam logic [3:0] HI_PRESSURE    = 4'hd;
  localparam logic [3:0] HI_BEND        = 4'he;

  typedef enum logic [6:0] {
    PH_DELTA     = 7'b0000001,
    PH_STATUS    = 7'b0000010,
    PH_DATA1     = 7'b0000100,
    PH_DATA2     = 7'b0001000,
    PH_META_TYPE = 7'b0010000,
    PH_META_LEN  = 7'b0100000,
    PH_META_BODY = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  channel;
    logic [6:0]  key_or_value;
    logic [6:0]  velocity;
    logic [13:0] bend_amount;
    logic [23:0] tempo_us;
    logic [31:0] event_time;
    logic        restart_track;
  } result_t;

endpackage

[sv/mesp_in_reg.sv]
// Input register stage holding one accepted track byte.
module mesp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] stream_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic accept;

  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= stream_byte;
    end
  end

endmodule

[sv/mesp_decode.sv]
// Parser state and the single-pass byte decode that forms one result.
module mesp_decode #(
  parameter int MAX_DELTA_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              advance,
  input  logic [7:0]        byte_in,
  output logic              emit,
  output mesp_pkg::result_t result
);
  import mesp_pkg::*;

  localparam logic [2:0] MaxBytes = 3'(MAX_DELTA_BYTES);

  phase_t      phase, phase_next;
  logic [7:0]  running_status, running_status_next;
  logic [6:0]  first_data, first_data_next;
  logic [27:0] delta_accum, delta_accum_next;
  logic [2:0]  delta_bytes, delta_bytes_next;
  logic [31:0] tick_time, tick_time_next;
  logic [7:0]  meta_type, meta_type_next;
  logic [7:0]  meta_remaining, meta_remaining_next;
  logic [23:0] tempo_shift, tempo_shift_next;
  logic [7:0]  loops_left, loops_left_next;
  logic        finished, finished_next;

  function automatic logic is_channel(input logic [7:0] s);
    return s[7:4] inside {HI_NOTE_OFF, HI_NOTE_ON, HI_PROGRAM, HI_PRESSURE, HI_BEND};
  endfunction

  always_comb begin
    logic        do_first;
    logic        do_meta;
    logic        do_done;
    logic [6:0]  d;
    logic [7:0]  rem_dec;
    logic [23:0] ts_body;
    phase_next          = phase;
    running_status_next = running_status;
    first_data_next     = first_data;
    delta_accum_next    = delta_accum;
    delta_bytes_next    = delta_bytes;
    tick_time_next      = tick_time;
    meta_type_next      = meta_type;
    meta_remaining_next = meta_remaining;
    tempo_shift_next    = tempo_shift;
    loops_left_next     = loops_left;
    finished_next       = finished;
    emit                = 1'b0;
    result              = '0;
    do_first            = 1'b0;
    do_meta             = 1'b0;
    do_done             = 1'b0;
    d                   = byte_in[6:0];
    rem_dec             = meta_remaining - 8'd1;
    ts_body             = {tempo_shift[15:0], byte_in};

    if (!finished) begin
      case (phase)
        PH_DELTA: begin
          delta_accum_next = {delta_accum[20:0], byte_in[6:0]};
          delta_bytes_next = delta_bytes + 3'd1;
          if (byte_in[7]) begin
            if (delta_bytes_next >= MaxBytes) begin
              emit          = 1'b1;
              finished_next = 1'b1;
            end
          end else begin
            tick_time_next   = tick_time + {4'd0, delta_accum_next};
            delta_accum_next = '0;
            delta_bytes_next = '0;
            phase_next       = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (byte_in[7]) begin
            running_status_next = byte_in;
            if (is_channel(byte_in)) begin
              phase_next = PH_DATA1;
            end else if (byte_in == STATUS_META) begin
              phase_next = PH_META_TYPE;
            end else begin
              emit          = 1'b1;
              finished_next = 1'b1;
            end
          end else if (is_channel(running_status)) begin
            do_first = 1'b1;
          end else if (running_status == STATUS_META) begin
            do_meta = 1'b1;
          end else begin
            emit          = 1'b1;
            finished_next = 1'b1;
          end
        end
        PH_DATA1: do_first = 1'b1;
        PH_DATA2: begin
          phase_next = PH_DELTA;
          emit       = 1'b1;
          result.key_or_value = first_data;
          if (running_status[7:4] == HI_BEND) begin
            result.event_kind  = KIND_BEND;
            result.key_or_value = '0;
            result.bend_amount = {d, first_data};
          end else if (running_status[7:4] == HI_NOTE_ON && d != 7'd0) begin
            result.event_kind = KIND_NOTE_ON;
            result.velocity   = d;
          end else begin
            result.event_kind = KIND_NOTE_OFF;
            result.velocity   = d;
          end
        end
        PH_META_TYPE: do_meta = 1'b1;
        PH_META_LEN: begin
          meta_remaining_next = byte_in;
          tempo_shift_next    = '0;
          if (byte_in == 8'd0) begin
            do_done = 1'b1;
          end else begin
            phase_next = PH_META_BODY;
          end
        end
        PH_META_BODY: begin
          tempo_shift_next    = ts_body;
          meta_remaining_next = rem_dec;
          if (rem_dec == 8'd0) begin
            do_done = 1'b1;
          end
        end
        default: phase_next = PH_DELTA;
      endcase

      if (do_first) begin
        first_data_next = d;
        if (running_status[7:4] == HI_PROGRAM) begin
          phase_next          = PH_DELTA;
          emit                = 1'b1;
          result.event_kind   = KIND_PROGRAM;
          result.key_or_value = d;
        end else if (running_status[7:4] == HI_PRESSURE) begin
          phase_next          = PH_DELTA;
          emit                = 1'b1;
          result.event_kind   = KIND_PRESSURE;
          result.key_or_value = d;
        end else begin
          phase_next = PH_DATA2;
        end
      end

      if (do_meta) begin
        meta_type_next = byte_in;
        if (byte_in == META_END_TRACK) begin
          phase_next        = PH_DELTA;
          emit              = 1'b1;
          result.event_kind = KIND_END;
          if (loops_left <= 8'd1) begin
            loops_left_next = '0;
            finished_next   = 1'b1;
          end else begin
            loops_left_next      = loops_left - 8'd1;
            result.restart_track = 1'b1;
          end
        end else begin
          phase_next = PH_META_LEN;
        end
      end

      if (do_done) begin
        phase_next = PH_DELTA;
        if (meta_type == META_TEMPO) begin
          emit              = 1'b1;
          result.event_kind = KIND_TEMPO;
          result.tempo_us   = tempo_shift_next;
        end
      end

      // An error result is flagged by finishing without any other kind set.
      if (emit && finished_next && !do_meta) begin
        result.event_kind = KIND_ERROR;
      end
    end

    result.channel    = running_status_next[3:0];
    result.event_time = tick_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      running_status <= '0;
      first_data     <= '0;
      delta_accum    <= '0;
      delta_bytes    <= '0;
      tick_time      <= '0;
      meta_type      <= '0;
      meta_remaining <= '0;
      tempo_shift    <= '0;
      loops_left     <= 8'd1;
      finished       <= 1'b0;
    end else begin
      if (advance) begin
        phase          <= phase_next;
        running_status <= running_status_next;
        first_data     <= first_data_next;
        delta_accum    <= delta_accum_next;
        delta_bytes    <= delta_bytes_next;
        tick_time      <= tick_time_next;
        meta_type      <= meta_type_next;
        meta_remaining <= meta_remaining_next;
        tempo_shift    <= tempo_shift_next;
        finished       <= finished_next;
      end
      if (cfg_we) begin
        loops_left <= cfg_wdata;
      end else if (advance) begin
        loops_left <= loops_left_next;
      end
    end
  end

endmodule

[sv/mesp_out_reg.sv]
// Result register that holds one decoded event until it is taken.
module mesp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mesp_pkg::result_t result_in,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              free,
  output mesp_pkg::result_t result_q
);
  import mesp_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

[sv/midi_event_stream_parser_top.sv]
// Top level of the MIDI track event parser with running status.
// A byte accepted into the input register is decoded from there, and its result (if any)
// is loaded into the result register when that register is free to take it.
// Throughput: one byte per cycle through the single decode pass between the
// input register and the result register; a result held by output stall holds the pipe.
// Reset (rst, synchronous, active high) clears all parser state; loops left starts at one.
module midi_event_stream_parser_top #(
  parameter int MAX_DELTA_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [3:0]  channel,
  output logic [6:0]  key_or_value,
  output logic [6:0]  velocity,
  output logic [13:0] bend_amount,
  output logic [23:0] tempo_us,
  output logic [31:0] event_time,
  output logic        restart_track
);
  import mesp_pkg::*;

  // The held byte is decoded whenever the result register can take a new
  // request, so a byte that makes no result also moves on at once.
  logic       held_valid;
  logic [7:0] held_byte;
  logic       free;
  logic       advance;
  logic       emit;
  result_t    result_comb;
  result_t    result_q;

  assign advance = held_valid && free;

  mesp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .stream_byte(stream_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  mesp_decode #(
    .MAX_DELTA_BYTES(MAX_DELTA_BYTES)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .advance  (advance),
    .byte_in  (held_byte),
    .emit     (emit),
    .result   (result_comb)
  );

  // The result register parts the two sides, so a new byte is accepted
  // while a finished result is still waiting to be taken.
  mesp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .result_in(result_comb),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .free     (free),
    .result_q (result_q)
  );

  assign event_kind    = result_q.event_kind;
  assign channel       = result_q.channel;
  assign key_or_value  = result_q.key_or_value;
  assign velocity      = result_q.velocity;
  assign bend_amount   = result_q.bend_amount;
  assign tempo_us      = result_q.tempo_us;
  assign event_time    = result_q.event_time;
  assign restart_track = result_q.restart_track;

endmodule

[test/tb_midi_event_stream_parser_top.sv]
// Self-checking testbench for the MIDI event stream parser top level.
`timescale 1ns / 100ps

module tb_midi_event_stream_parser_top;
  import mesp_pkg::*;

  // Delta length limit handed to the block, and the sysex status that it must reject.
  localparam int DELTA_LIMIT = 4;
  localparam logic [7:0] STATUS_SYSEX = 8'hf0;

  // Run shape. The block registers each accepted byte and then its result, so a few idle
  // cycles after the last result are enough for any request still in flight.
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam longint LIMIT_NS = 20_000_000;

  // The run can end the parser in only one way, since reset is applied once.
  typedef enum int {
    HALT_COMPLETE,
    HALT_LONG_DELTA,
    HALT_SYSEX,
    HALT_SYSTEM
  } halt_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  stream_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  event_kind;
  logic [3:0]  channel;
  logic [6:0]  key_or_value;
  logic [6:0]  velocity;
  logic [13:0] bend_amount;
  logic [23:0] tempo_us;
  logic [31:0] event_time;
  logic        restart_track;

  // Idling controls shared by the sender, the receiver process and the tests.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold_cycles = 0;

  // Events that the parser owes us, oldest first, and the failure count.
  result_t expected_events [$];
  int      fail_count = 0;
  int      bytes_sent = 0;

  // Our own copy of the parser state, advanced on every accepted request.
  phase_t      cur_phase;
  logic [7:0]  held_status;
  logic [6:0]  data_lo;
  logic [27:0] delta_sum;
  logic [2:0]  delta_len;
  logic [31:0] track_ticks;
  logic [7:0]  meta_code;
  logic [7:0]  meta_left;
  logic [23:0] tempo_bits;
  logic [7:0]  plays_left;
  bit          parser_halted;

  midi_event_stream_parser_top #(
    .MAX_DELTA_BYTES(DELTA_LIMIT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .stream_byte  (stream_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .channel      (channel),
    .key_or_value (key_or_value),
    .velocity     (velocity),
    .bend_amount  (bend_amount),
    .tempo_us     (tempo_us),
    .event_time   (event_time),
    .restart_track(restart_track)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Event prediction
  // ---------------------------------------------------------------------------

  function automatic bit is_channel(input logic [7:0] s);
    return s[7:4] == HI_NOTE_OFF || s[7:4] == HI_NOTE_ON || s[7:4] == HI_PROGRAM ||
           s[7:4] == HI_PRESSURE || s[7:4] == HI_BEND;
  endfunction

  // Every event carries the channel of the held status and the current tick time.
  task automatic push_event(input logic [2:0] kind, input logic [6:0] key,
                            input logic [6:0] vel, input logic [13:0] bend,
                            input logic [23:0] tempo, input logic restart);
    result_t r;
    r.event_kind    = kind;
    r.channel       = held_status[3:0];
    r.key_or_value  = key;
    r.velocity      = vel;
    r.bend_amount   = bend;
    r.tempo_us      = tempo;
    r.event_time    = track_ticks;
    r.restart_track = restart;
    expected_events.push_back(r);
  endtask

  // Any error stops the parser for good; it reports the error once.
  task automatic raise_error();
    parser_halted = 1'b1;
    push_event(KIND_ERROR, 7'd0, 7'd0, 14'd0, 24'd0, 1'b0);
  endtask

  // Program and pressure end on their single data byte; the others wait for a second.
  task automatic take_data1(input logic [7:0] b);
    data_lo = b[6:0];
    if (held_status[7:4] == HI_PROGRAM) begin
      cur_phase = PH_DELTA;
      push_event(KIND_PROGRAM, data_lo, 7'd0, 14'd0, 24'd0, 1'b0);
    end else if (held_status[7:4] == HI_PRESSURE) begin
      cur_phase = PH_DELTA;
      push_event(KIND_PRESSURE, data_lo, 7'd0, 14'd0, 24'd0, 1'b0);
    end else begin
      cur_phase = PH_DATA2;
    end
  endtask

  task automatic take_data2(input logic [7:0] b);
    cur_phase = PH_DELTA;
    if (held_status[7:4] == HI_BEND)
      push_event(KIND_BEND, 7'd0, 7'd0, {b[6:0], data_lo}, 24'd0, 1'b0);
    else if (held_status[7:4] == HI_NOTE_ON && b[6:0] != 7'd0)
      push_event(KIND_NOTE_ON, data_lo, b[6:0], 14'd0, 24'd0, 1'b0);
    else
      push_event(KIND_NOTE_OFF, data_lo, b[6:0], 14'd0, 24'd0, 1'b0);
  endtask

  // End of track either asks for a restart or completes the track and halts.
  task automatic take_meta_type(input logic [7:0] b);
    meta_code = b;
    if (b == META_END_TRACK) begin
      cur_phase = PH_DELTA;
      if (plays_left <= 8'd1) begin
        plays_left = 8'd0;
        parser_halted = 1'b1;
        push_event(KIND_END, 7'd0, 7'd0, 14'd0, 24'd0, 1'b0);
      end else begin
        plays_left = plays_left - 8'd1;
        push_event(KIND_END, 7'd0, 7'd0, 14'd0, 24'd0, 1'b1);
      end
    end else begin
      cur_phase = PH_META_LEN;
    end
  endtask

  task automatic finish_meta();
    cur_phase = PH_DELTA;
    if (meta_code == META_TEMPO)
      push_event(KIND_TEMPO, 7'd0, 7'd0, 14'd0, tempo_bits, 1'b0);
  endtask

  task automatic track_byte(input logic [7:0] b);
    if (parser_halted)
      return;
    case (cur_phase)
      PH_DELTA: begin
        delta_sum = {delta_sum[20:0], b[6:0]};
        delta_len = delta_len + 3'd1;
        if (b[7]) begin
          if (delta_len >= DELTA_LIMIT)
            raise_error();
        end else begin
          track_ticks = track_ticks + {4'd0, delta_sum};
          delta_sum = 28'd0;
          delta_len = 3'd0;
          cur_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          held_status = b;
          if (is_channel(b))
            cur_phase = PH_DATA1;
          else if (b == STATUS_META)
            cur_phase = PH_META_TYPE;
          else
            raise_error();
        end else if (is_channel(held_status)) begin
          take_data1(b);
        end else if (held_status == STATUS_META) begin
          take_meta_type(b);
        end else begin
          raise_error();
        end
      end
      PH_DATA1:     take_data1(b);
      PH_DATA2:     take_data2(b);
      PH_META_TYPE: take_meta_type(b);
      PH_META_LEN: begin
        meta_left = b;
        tempo_bits = 24'd0;
        if (b == 8'd0)
          finish_meta();
        else
          cur_phase = PH_META_BODY;
      end
      PH_META_BODY: begin
        tempo_bits = {tempo_bits[15:0], b};
        meta_left = meta_left - 8'd1;
        if (meta_left == 8'd0)
          finish_meta();
      end
      default: cur_phase = PH_DELTA;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------------

  // Offers one byte at the falling edge and holds it until a rising edge sees
  // valid with no stall. The prediction runs at that same edge, ahead of the earliest
  // result that the byte can cause.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_byte(b);
    bytes_sent++;
  endtask

  // Variable-length delta in exactly nbytes bytes, most significant group first.
  task automatic send_delta(input logic [27:0] value, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--)
      send_byte({i != 0, value[7*i +: 7]});
  endtask

  // Drops valid and waits until every owed event has arrived, then lets the
  // pipeline settle so that a byte with no event is also fully consumed.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The loop register is written only with the parser idle; a write also
  // reloads the remaining play count.
  task automatic write_loop_count(input logic [7:0] v);
    wait_for_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    plays_left   = v;
  endtask

  // Data positions accept any byte, so a quarter of them carry a set top bit.
  function automatic logic [7:0] random_data();
    logic [7:0] b;
    b = 8'($urandom_range(0, 127));
    if ($urandom_range(0, 3) == 0)
      b[7] = 1'b1;
    return b;
  endfunction

  // One well-formed event with random content: a delta of one to four bytes,
  // then a channel event or a meta event, reusing the running status at times.
  // End of track is only produced while it restarts the track, so the parser
  // keeps running.
  task automatic send_random_event(input bit allow_end);
    int          nbytes;
    int          pick;
    int          len;
    logic [27:0] mask;
    logic [27:0] value;
    logic [3:0]  hi;
    logic [7:0]  mtype;
    bit          reuse;

    pick   = $urandom_range(0, 9);
    nbytes = (pick < 6) ? 1 : (pick < 8) ? 2 : (pick < 9) ? 3 : 4;
    mask   = (28'd1 << (7 * nbytes)) - 28'd1;
    value  = 28'($urandom()) & mask;
    if ($urandom_range(0, 15) == 0)
      value = mask;
    send_delta(value, nbytes);

    if ($urandom_range(0, 99) < 72) begin
      case ($urandom_range(0, 4))
        0: hi = HI_NOTE_OFF;
        1: hi = HI_NOTE_ON;
        2: hi = HI_PROGRAM;
        3: hi = HI_PRESSURE;
        default: hi = HI_BEND;
      endcase
      reuse = is_channel(held_status) && $urandom_range(0, 2) == 0;
      if (reuse) begin
        // With running status the first data byte sits in status position,
        // so its top bit must be clear.
        hi = held_status[7:4];
        send_byte(8'($urandom_range(0, 127)));
      end else begin
        send_byte({hi, 4'($urandom_range(0, 15))});
        send_byte(random_data());
      end
      if (hi != HI_PROGRAM && hi != HI_PRESSURE) begin
        if (hi == HI_NOTE_ON && $urandom_range(0, 5) == 0)
          send_byte({1'($urandom_range(0, 1)), 7'd0});
        else
          send_byte(random_data());
      end
    end else begin
      reuse = (held_status == STATUS_META) && $urandom_range(0, 1) == 0;
      if (!reuse)
        send_byte(STATUS_META);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        mtype = META_TEMPO;
      end else if (pick < 6 && allow_end && plays_left > 8'd1) begin
        mtype = META_END_TRACK;
      end else begin
        do
          mtype = reuse ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 255));
        while (mtype == META_END_TRACK || mtype == META_TEMPO);
      end
      send_byte(mtype);
      if (mtype == META_END_TRACK)
        return;
      if ($urandom_range(0, 149) == 0)
        len = $urandom_range(128, 160);
      else if (mtype == META_TEMPO && $urandom_range(0, 9) < 6)
        len = 3;
      else
        len = $urandom_range(0, 6);
      send_byte(8'(len));
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------

  // Stall comes in random bursts. A long hold, counted here cycle by cycle,
  // overrides the bursts so that the block fills up and stalls its input.
  initial begin : receiver_stall
    int burst_left;
    bit burst_stall;
    burst_left  = 0;
    burst_stall = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall <= 1'b1;
        rx_hold_cycles = rx_hold_cycles - 1;
      end else if (!rx_idle_on) begin
        out_stall <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_stall = ($urandom_range(0, 2) == 0);
          burst_left  = $urandom_range(1, 19);
        end
        out_stall <= burst_stall;
        burst_left--;
      end
    end
  end

  function automatic string show_event(input result_t r);
    return $sformatf("kind=%0d ch=%0d key=%0d vel=%0d bend=%0d tempo=%06h time=%08h restart=%0b",
                     r.event_kind, r.channel, r.key_or_value, r.velocity, r.bend_amount,
                     r.tempo_us, r.event_time, r.restart_track);
  endfunction

  // Every accepted result is matched against the oldest owed event.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.event_kind    = event_kind;
      got.channel       = channel;
      got.key_or_value  = key_or_value;
      got.velocity      = velocity;
      got.bend_amount   = bend_amount;
      got.tempo_us      = tempo_us;
      got.event_time    = event_time;
      got.restart_track = restart_track;
      if (expected_events.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: event with none owed: %s", $time, show_event(got));
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                     show_event(want), show_event(got));
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every channel kind: both ends of the data range, channels 0 and 15, data
  // bytes with the top bit set, zero velocity note on, and running status.
  task automatic test_channel_events();
    write_loop_count(8'd255);
    send_delta(28'd0, 1);    send_byte(8'h90); send_byte(8'h00); send_byte(8'h7f);
    send_delta(28'h7f, 1);   send_byte(8'h7f); send_byte(8'h00);
    send_delta(28'd1, 1);    send_byte(8'h8f); send_byte(8'hc5); send_byte(8'h80);
    send_delta(28'd2, 1);    send_byte(8'hcf); send_byte(8'h7f);
    send_delta(28'd3, 1);    send_byte(8'hd3); send_byte(8'h00);
    send_delta(28'd0, 1);    send_byte(8'he0); send_byte(8'h7f); send_byte(8'h7f);
    send_delta(28'd0, 1);    send_byte(8'h00); send_byte(8'h00);
    send_delta(28'd5, 1);    send_byte(8'h01); send_byte(8'hc0);
    send_delta(28'd9, 1);    send_byte(8'h9a); send_byte(8'h3c); send_byte(8'h40);
  endtask

  // Deltas of two, three and four bytes, the largest value, and zero padded to four bytes.
  task automatic test_delta_lengths();
    send_delta(28'hfffffff, 4); send_byte(8'hc0); send_byte(8'h01);
    send_delta(28'd0, 4);       send_byte(8'h02);
    send_delta(28'h1fffff, 3);  send_byte(8'h03);
    send_delta(28'h80, 2);      send_byte(8'h04);
  endtask

  // Tempo with full, empty, short and long bodies, skipped meta events, a meta
  // type under running status, and end of track that restarts the track.
  task automatic test_meta_events();
    write_loop_count(8'd3);
    send_delta(28'd0, 1);
    send_byte(STATUS_META); send_byte(META_TEMPO); send_byte(8'h03);
    send_byte(8'h07); send_byte(8'ha1); send_byte(8'h20);
    send_delta(28'd1, 1);
    send_byte(STATUS_META); send_byte(META_TEMPO); send_byte(8'h00);
    send_delta(28'd2, 1);
    send_byte(STATUS_META); send_byte(META_TEMPO); send_byte(8'h01); send_byte(8'hff);
    send_delta(28'd3, 1);
    send_byte(STATUS_META); send_byte(META_TEMPO); send_byte(8'h05);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'h44); send_byte(8'h55);
    send_delta(28'd4, 1);
    send_byte(STATUS_META); send_byte(8'h03); send_byte(8'h02);
    send_byte(8'h41); send_byte(8'h42);
    send_delta(28'd0, 1);
    send_byte(STATUS_META); send_byte(8'h01); send_byte(8'h00);
    send_delta(28'd6, 1);
    send_byte(META_TEMPO); send_byte(8'h03);
    send_byte(8'h0f); send_byte(8'h42); send_byte(8'h40);
    send_delta(28'd7, 1);
    send_byte(STATUS_META); send_byte(META_END_TRACK);
    send_delta(28'd0, 1);
    send_byte(META_END_TRACK);
  endtask

  // Long random stream in phases, each with its own loop setting. With a
  // setting of 0, 1 or 2 the stream avoids the end of track that would complete.
  task automatic test_random_stream();
    logic [7:0] settings [5];
    int         phase_start;
    settings = '{8'd255, 8'($urandom_range(2, 254)), 8'd2, 8'd0, 8'd1};
    foreach (settings[i]) begin
      write_loop_count(settings[i]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RANDOM_ITEMS / 5)
        send_random_event(1'b1);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // requests; afterward the sender pauses until every owed event is in.
  task automatic test_backpressure();
    write_loop_count(8'($urandom_range(100, 254)));
    rx_hold_cycles = HOLD_CYCLES;
    repeat (40) send_random_event(1'b1);
    wait_for_results();
    repeat (20) send_random_event(1'b1);
  endtask

  // Back to back requests and results with no idling on either side.
  task automatic test_full_rate();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (60) send_random_event(1'b1);
  endtask

  // The one terminal condition of the run, picked at random, followed by
  // bytes that the halted parser must ignore.
  task automatic test_halt_condition();
    halt_t mode;
    mode = halt_t'($urandom_range(0, 3));
    case (mode)
      HALT_COMPLETE: begin
        write_loop_count(8'($urandom_range(0, 1)));
        send_delta(28'd1, 1);
        send_byte(STATUS_META);
        send_byte(META_END_TRACK);
      end
      HALT_LONG_DELTA: begin
        repeat (DELTA_LIMIT) send_byte(8'h80 | 8'($urandom_range(0, 127)));
      end
      HALT_SYSEX: begin
        send_delta(28'd2, 1);
        send_byte(STATUS_SYSEX);
      end
      default: begin
        send_delta(28'd3, 1);
        send_byte(8'($urandom_range(8'hf1, 8'hfe)));
      end
    endcase
    repeat (12) send_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = 8'd0;
    in_valid    = 1'b0;
    stream_byte = 8'd0;

    // Reset state of our parser copy; the block loads a loop count of one.
    cur_phase     = PH_DELTA;
    held_status   = 8'd0;
    data_lo       = 7'd0;
    delta_sum     = 28'd0;
    delta_len     = 3'd0;
    track_ticks   = 32'd0;
    meta_code     = 8'd0;
    meta_left     = 8'd0;
    tempo_bits    = 24'd0;
    plays_left    = 8'd1;
    parser_halted = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_channel_events();
    test_delta_lengths();
    test_meta_events();
    test_random_stream();
    test_backpressure();
    test_full_rate();
    test_halt_condition();

    wait_for_results();
    if (fail_count == 0 && expected_events.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
